### hw/rtl/mf3_pkg.sv
package mf3_pkg;

    localparam int PIX_W         = 8;
    localparam int DEF_MAX_WIDTH = 1024;
    localparam int CFG_WIDTH_W   = 11;
    localparam int CFG_HEIGHT_W  = 16;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_in;
        logic             flush;
    } t_pix_in;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             frame_last;
    } t_pix_out;

    typedef struct packed {
        t_pix lo;
        t_pix md;
        t_pix hi;
    } t_col;

    function automatic t_pix min2(input t_pix a, input t_pix b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_pix max2(input t_pix a, input t_pix b);
        return (a < b) ? b : a;
    endfunction

    function automatic t_pix min3(input t_pix a, input t_pix b, input t_pix c);
        return min2(min2(a, b), c);
    endfunction

    function automatic t_pix max3(input t_pix a, input t_pix b, input t_pix c);
        return max2(max2(a, b), c);
    endfunction

    function automatic t_pix med3(input t_pix a, input t_pix b, input t_pix c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    function automatic t_col sort3(input t_pix a, input t_pix b, input t_pix c);
        t_col s;
        s.lo = min3(a, b, c);
        s.md = med3(a, b, c);
        s.hi = max3(a, b, c);
        return s;
    endfunction

endpackage

### hw/rtl/median_filter_3x3.sv
// 3x3 median filter for 8-bit grayscale frames streamed in raster order.
// input channel: i_in_valid / o_in_stall, word = pixel_in plus flush flag.
// output channel: o_out_valid / i_out_stall, word = pixel_out plus frame_last.
// config channel: i_cfg_valid / o_cfg_ready (always ready), index 0 sets the
// image width, index 1 the image height; a write to either restarts the frame.
// one input word per clock is sustained while i_out_stall is low; each stage
// (row store read, window shift with column sort, median select) is one register.
// a result passes through each stage register after its window is complete;
// in stream terms output trails input by image_width+1 words, so after
// the last pixel of a frame send image_width+1 flush words; the final result
// carries frame_last and the next word starts a new frame.
// while i_out_stall is high the output register holds, and stall backs up
// through the two internal stages to o_in_stall within the same cycle.
// reset: width 640, height 480, all position counters cleared, pipeline empty;
// row store contents are undefined until written and only feed border results
// during the first two rows.
module median_filter_3x3
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  t_pix_in               i_in_data,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output t_pix_out              o_out_data,
    input  logic                  i_out_stall,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int EWR = $clog2(MAX_WIDTH + 1);
    localparam int EW  = (EWR > CFG_WIDTH_W) ? EWR : CFG_WIDTH_W;

    logic [CFG_WIDTH_W-1:0]  r_cfg_width;
    logic [CFG_HEIGHT_W-1:0] r_cfg_height;

    logic [EW-1:0]           w_raw;
    logic [EW-1:0]           w_eff;
    logic [CW-1:0]           w_m1;
    logic [CW-1:0]           w_m2;
    logic [CFG_HEIGHT_W-1:0] h_eff;
    logic [CFG_HEIGHT_W-1:0] h_m1;
    logic [CFG_HEIGHT_W-1:0] h_m2;

    logic [CW-1:0]           r_in_col, n_in_col;
    logic [1:0]              r_in_row, n_in_row;
    logic [CW-1:0]           r_out_col, n_out_col;
    logic [CFG_HEIGHT_W-1:0] r_out_row, n_out_row;

    t_pix r_upper_mem [MAX_WIDTH];
    t_pix r_mid_mem   [MAX_WIDTH];

    logic    r_s1_vld;
    logic    r_s1_res;
    logic    r_s1_int;
    logic    r_s1_last;
    logic [CW-1:0] r_s1_col;
    t_pix    r_s1_px;
    t_pix    r_top_rd;
    t_pix    r_mid_rd;

    logic    r_s2_vld;
    logic    r_s2_int;
    logic    r_s2_last;

    t_col    r_win [3];
    t_pix    r_raw_mid1;
    t_pix    r_raw_mid2;

    logic     r_o_vld;
    t_pix_out r_o_data;

    logic cfg_wr;
    logic acc;
    logic o_free;
    logic s2_free;
    logic s1_adv;
    logic res;
    logic interior;
    logic last;
    t_pix px;
    t_pix med;
    t_col col_new;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid &&
                         (i_cfg_index inside {CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT});

    // effective frame geometry
    always_comb begin
        w_raw = EW'(r_cfg_width);
        if (w_raw < EW'(3)) begin
            w_eff = EW'(3);
        end else if (w_raw > EW'(MAX_WIDTH)) begin
            w_eff = EW'(MAX_WIDTH);
        end else begin
            w_eff = w_raw;
        end
        w_m1  = CW'(w_eff - EW'(1));
        w_m2  = CW'(w_eff - EW'(2));
        h_eff = (r_cfg_height < 16'd3) ? 16'd3 : r_cfg_height;
        h_m1  = h_eff - 16'd1;
        h_m2  = h_eff - 16'd2;
    end

    // pipeline flow
    assign o_free     = !r_o_vld || !i_out_stall;
    assign s2_free    = !r_s2_vld || o_free;
    assign s1_adv     = r_s1_vld && s2_free;
    assign o_in_stall = r_s1_vld && !s2_free;
    assign acc        = i_in_valid && !o_in_stall;

    assign px = i_in_data.flush ? '0 : i_in_data.pixel_in;

    // position tracking at accept
    always_comb begin
        res      = (r_in_row == 2'd2) || (r_in_row == 2'd1 && r_in_col != '0);
        interior = (r_out_row >= 16'd1) && (r_out_row <= h_m2) &&
                   (r_out_col != '0) && (r_out_col <= w_m2);
        last     = (r_out_row >= h_m1) && (r_out_col == w_m1);

        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (cfg_wr) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end else if (acc) begin
            if (r_in_col == w_m1) begin
                n_in_col = '0;
                if (r_in_row != 2'd2) begin
                    n_in_row = r_in_row + 2'd1;
                end
            end else begin
                n_in_col = r_in_col + CW'(1);
            end
            if (res) begin
                if (last) begin
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                end else if (r_out_col == w_m1) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + 16'd1;
                end else begin
                    n_out_col = r_out_col + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= WIDTH_RESET;
            r_cfg_height <= HEIGHT_RESET;
            r_in_col     <= '0;
            r_in_row     <= '0;
            r_out_col    <= '0;
            r_out_row    <= '0;
            r_s1_vld     <= 1'b0;
            r_s2_vld     <= 1'b0;
            r_o_vld      <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_data[CFG_WIDTH_W-1:0];
                    CFG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_data;
                    default: ;
                endcase
            end
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            if (acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_s2_vld <= r_s1_res;
            end else if (s2_free) begin
                r_s2_vld <= 1'b0;
            end
            if (r_s2_vld && o_free) begin
                r_o_vld <= 1'b1;
            end else if (o_free) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    // row stores
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_top_rd           <= r_upper_mem[r_in_col];
            r_mid_rd           <= r_mid_mem[r_in_col];
            r_mid_mem[r_in_col] <= px;
        end
        if (s1_adv) begin
            r_upper_mem[r_s1_col] <= r_mid_rd;
        end
    end

    assign col_new = sort3(r_top_rd, r_mid_rd, r_s1_px);
    assign med = med3(max3(r_win[0].lo, r_win[1].lo, r_win[2].lo),
                      med3(r_win[0].md, r_win[1].md, r_win[2].md),
                      min3(r_win[0].hi, r_win[1].hi, r_win[2].hi));

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_px   <= px;
            r_s1_col  <= r_in_col;
            r_s1_res  <= res;
            r_s1_int  <= interior;
            r_s1_last <= last;
        end
        if (s1_adv) begin
            r_win[0]   <= r_win[1];
            r_win[1]   <= r_win[2];
            r_win[2]   <= col_new;
            r_raw_mid1 <= r_raw_mid2;
            r_raw_mid2 <= r_mid_rd;
            r_s2_int   <= r_s1_int;
            r_s2_last  <= r_s1_last;
        end
        if (r_s2_vld && o_free) begin
            r_o_data.pixel_out  <= r_s2_int ? med : r_raw_mid1;
            r_o_data.frame_last <= r_s2_last;
        end
    end

    assign o_out_valid = r_o_vld;
    assign o_out_data  = r_o_data;

    a_in_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_col <= w_m1)
        else $error("input column beyond row end");

    a_out_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_col <= w_m1)
        else $error("output column beyond row end");

    a_out_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_row <= h_m1)
        else $error("output row beyond frame end");

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && res && last && !cfg_wr |=> r_in_col == '0 && r_in_row == '0 &&
        r_out_col == '0 && r_out_row == '0)
        else $error("frame end did not restart position counters");

endmodule
